/* sv/iss_pkg.sv */
`default_nettype none
package iss_pkg;

   // payload width of the stream data ports
   localparam int DATA_W = 32;

   // defaults for the top level parameters
   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_DRAIN
   } state_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;   // place the new value, move larger ones up one cell
      logic shift;    // move every cell down one place toward the output
   } cell_ctl_type;

endpackage
`default_nettype wire

/* sv/iss_cell.sv */
`default_nettype none
module iss_cell #(
   parameter int WIDTH = iss_pkg::WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire iss_pkg::cell_ctl_type ctl,
   input  wire logic [WIDTH-1:0]     new_value,
   input  wire logic [WIDTH-1:0]     prev_value,
   input  wire logic                 prev_valid,
   input  wire logic                 prev_gt,
   input  wire logic [WIDTH-1:0]     next_value,
   input  wire logic                 next_valid,
   output logic      [WIDTH-1:0]     value,
   output logic                      valid,
   output logic                      gt
);
   import iss_pkg::*;

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;
   logic             valid_ff;
   logic             valid_in;

   // stored entry is strictly greater than the incoming value
   assign gt = valid_ff && (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctl.insert) begin
         if (prev_gt) begin
            value_in = prev_value;
            valid_in = 1'b1;
         end else if ((gt || !valid_ff) && prev_valid) begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

/* sv/iss_ctrl.sv */
`default_nettype none
module iss_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tready,
   input  wire logic                  full,
   input  wire logic                  more,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   output logic                       dropped,
   output iss_pkg::cell_ctl_type      ctl
);
   import iss_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      dropped_ff;
   logic      dropped_in;
   logic      req_fire;
   logic      rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && !more) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_FILL:  req_tready = 1'b1;
         ST_DRAIN: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_comb begin
      ctl.insert = req_fire && !full;
      ctl.shift  = rsp_fire;
      dropped_in = dropped_ff;
      if (req_fire && full) begin
         dropped_in = 1'b1;
      end else if (rsp_fire && !more) begin
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign dropped = dropped_ff;

endmodule
`default_nettype wire

/* sv/insertion_sorter_unit.sv */
`default_nettype none
// insertion sorter: collects a batch of unsigned values and returns it sorted
// - req channel: one value per item (low WIDTH bits of req_tdata used),
//   req_tlast marks the final value of the batch
// - rsp channel: the batch in ascending order, equal values in arrival order;
//   rsp_tlast marks the final result, rsp_tuser flags a batch that overflowed
// - fill: one item per cycle; a chain of DEPTH compare-and-shift cells places
//   each value as it is taken, so req_tready stays high while collecting
// - drain: after the last item the chain shifts toward cell zero, one result
//   per cycle while rsp_tready is high; the first result is offered the
//   cycle after the last item; a batch is taken in whole (dropped ones
//   included) before it drains; no new item is taken while a batch drains
// - values beyond DEPTH are dropped; every result of that batch has tuser set
// - a stalled receiver simply holds the chain, the head result stays on rsp
// - synchronous reset empties the chain and returns to collecting
module insertion_sorter_unit #(
   parameter int DEPTH = iss_pkg::DEPTH_DEF,
   parameter int WIDTH = iss_pkg::WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [iss_pkg::DATA_W-1:0] req_tdata,   // [31:0] value
   input  wire logic                       req_tlast,   // last_item
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [iss_pkg::DATA_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                            rsp_tlast,   // last_result
   output logic                            rsp_tuser    // [0] overflow
);
   import iss_pkg::*;

   // chain taps: index i+1 is cell i, index 0 feeds cell zero's output side,
   // index DEPTH+1 is the empty slot past the top cell
   logic [WIDTH-1:0] tap_value [DEPTH+1:0];
   logic             tap_valid [DEPTH+1:0];
   logic             tap_gt    [DEPTH:0];

   logic [WIDTH-1:0] new_value;
   cell_ctl_type     ctl;
   logic             dropped;

   assign new_value = req_tdata[WIDTH-1:0];

   // boundary of the chain: nothing ranks above cell zero
   assign tap_value[0]       = '0;
   assign tap_valid[0]       = 1'b1;
   assign tap_gt[0]          = 1'b0;
   assign tap_value[DEPTH+1] = '0;
   assign tap_valid[DEPTH+1] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      iss_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_value  (new_value),
         .prev_value (tap_value[i]),
         .prev_valid (tap_valid[i]),
         .prev_gt    (tap_gt[i]),
         .next_value (tap_value[i+2]),
         .next_valid (tap_valid[i+2]),
         .value      (tap_value[i+1]),
         .valid      (tap_valid[i+1]),
         .gt         (tap_gt[i+1])
      );
   end

   // the top cell holds a value only when the chain is full
   iss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .full       (tap_valid[DEPTH]),
      .more       (tap_valid[2]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .dropped    (dropped),
      .ctl        (ctl)
   );

   // head of the chain is the smallest remaining value
   assign rsp_tdata = DATA_W'(tap_value[1]);
   assign rsp_tlast = !tap_valid[2];
   assign rsp_tuser = dropped;

endmodule
`default_nettype wire
